[src/deq_pkg.sv]
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_FRONT    = 3'd0,
    REQ_ADD_BACK     = 3'd1,
    REQ_DUMP         = 3'd2,
    REQ_REMOVE_FRONT = 3'd3,
    REQ_REMOVE_BACK  = 3'd4
  } req_code_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_FULL       = 2'd2,
    STAT_DUMP_EMPTY = 2'd3
  } status_code_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } deq_state_t;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;
  } out_beat_t;

endpackage

`default_nettype wire

[src/deq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/double_ended_queue_core.sv]
// Top level of the bounded double-ended queue held in a ring RAM.
//
// Input channel (in_valid, in_stall, in_data): one request beat per item,
// add front, add back, dump, remove front or remove back. Selector codes
// 5 to 7 are taken and dropped without a result.
// Result channel (out_valid, out_stall, out_data): one registered beat per
// result. Add and remove give one status beat; a dump gives one beat per
// stored element, front to back, with last set on the final one, or one
// dump-empty beat when the queue holds nothing.
// Timing: a status beat is registered in the cycle after its request is
// accepted; each dump element passes through the registered RAM read port
// and then the result register, one per cycle while out_stall is low.
// Add, remove and ignored requests can be taken back to back while out_stall
// is low; a dump holds in_stall high until its final element is registered.
// Reset empties the queue (head and count to zero) and drops any pending
// result; RAM contents are not cleared.
// While a beat is pending and out_stall is high, the result register holds
// it and in_stall rises, so no request is taken until the beat leaves.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core #(
  parameter int DEPTH = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire deq_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output deq_pkg::out_beat_t       out_data
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  deq_state_t      state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_beat_t       out_data_r, out_data_nxt;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [31:0]     rd_data;

  logic            in_accept;
  logic            out_free;
  logic            is_full;
  logic            is_empty;
  logic [CW-1:0]   idx_inc;
  logic [AW-1:0]   head_dec;
  logic [AW-1:0]   head_inc;

  deq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign is_full   = (cnt_r == FULL_CNT);
  assign is_empty  = (cnt_r == '0);
  assign idx_inc   = CW'(idx_r) + CW'(1);
  assign head_dec  = (head_r == '0) ? LAST_POS : head_r - AW'(1);
  assign head_inc  = (head_r == LAST_POS) ? '0 : head_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = head_r;
    rd_en         = 1'b0;
    rd_addr       = head_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          out_data_nxt.element = '0;
          out_data_nxt.status  = STAT_OK;
          out_data_nxt.last    = 1'b1;
          unique case (in_data.req_type)
            REQ_ADD_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                head_nxt = head_dec;
                wr_en    = 1'b1;
                wr_addr  = head_dec;
                cnt_nxt  = cnt_r + CW'(1);
              end
            end
            REQ_ADD_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_full) begin
                out_data_nxt.status = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_r, cnt_r[AW-1:0]);
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            REQ_DUMP: begin
              if (is_empty) begin
                out_valid_nxt       = 1'b1;
                out_data_nxt.status = STAT_DUMP_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = head_r;
                idx_nxt   = '0;
                state_nxt = ST_DUMP;
              end
            end
            REQ_REMOVE_FRONT: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                head_nxt = head_inc;
                cnt_nxt  = cnt_r - CW'(1);
              end
            end
            REQ_REMOVE_BACK: begin
              out_valid_nxt = 1'b1;
              if (is_empty) begin
                out_data_nxt.status = STAT_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CW'(1);
              end
            end
            default: begin
              out_data_nxt = out_data_r;
            end
          endcase
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.element = rd_data;
          out_data_nxt.status  = STAT_OK;
          out_data_nxt.last    = (idx_inc == cnt_r);
          if (idx_inc == cnt_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = wrap_add(head_r, idx_r + AW'(1));
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
